[design/crg_pkg.sv]
// shared constants and helpers of the complex rotation generator
// no dependencies

package crg_pkg;

    localparam int CRG_DATA_WIDTH = 32;
    localparam int CRG_INT_BITS   = 4;

    // cycles through one phase/magnitude generator for a given fraction width
    function automatic int gen_latency(input int frac);
        return 3 * frac + 9;
    endfunction

endpackage

[design/crg_div.sv]
// pipelined restoring divider, one quotient bit per stage, shared divisor
// lanes; computes floor(num * 2^QF / den) for num <= den; no dependencies

module crg_div #(
    parameter int DW = 32,
    parameter int QF = 28,
    parameter int NL = 1,
    parameter int SW = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [NL-1:0][DW-1:0]    in_num,
    input  logic [DW-1:0]            in_den,
    input  logic [SW-1:0]            in_side,
    output logic                     out_valid,
    output logic [NL-1:0][QF:0]      out_quo,
    output logic [SW-1:0]            out_side
);

    localparam int NS = QF + 1;

    logic [NS-1:0]             valid_reg;
    logic [DW-1:0]             den_reg [NS];
    logic [SW-1:0]             side_reg [NS];
    logic [NL-1:0][DW-1:0]     rem_reg [NS];
    logic [NL-1:0][QF:0]       quo_reg [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            localparam bit FIRST = (g == 0);
            logic                  valid_in;
            logic [DW-1:0]         den_in;
            logic [SW-1:0]         side_in;
            logic [NL-1:0][DW-1:0] rem_in;
            logic [NL-1:0][QF:0]   quo_in;
            logic [NL-1:0][DW-1:0] rem_next;
            logic [NL-1:0][QF:0]   quo_next;
            logic [NL-1:0][DW:0]   trial;
            logic [NL-1:0][DW:0]   diff;
            logic [NL-1:0]         ge;

            if (g == 0) begin : g_first
                assign valid_in = in_valid;
                assign den_in   = in_den;
                assign side_in  = in_side;
                assign rem_in   = in_num;
                assign quo_in   = '0;
            end else begin : g_next
                assign valid_in = valid_reg[g-1];
                assign den_in   = den_reg[g-1];
                assign side_in  = side_reg[g-1];
                assign rem_in   = rem_reg[g-1];
                assign quo_in   = quo_reg[g-1];
            end

            always_comb begin
                for (int l = 0; l < NL; l++) begin
                    trial[l]    = FIRST ? {1'b0, rem_in[l]} : {rem_in[l], 1'b0};
                    ge[l]       = trial[l] >= {1'b0, den_in};
                    diff[l]     = trial[l] - {1'b0, den_in};
                    rem_next[l] = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
                    quo_next[l] = {quo_in[l][QF-1:0], ge[l]};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (en) begin
                    valid_reg[g] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[g]  <= den_in;
                    side_reg[g] <= side_in;
                    rem_reg[g]  <= rem_next;
                    quo_reg[g]  <= quo_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[design/crg_sqrt.sv]
// pipelined digit-by-digit square root, one root bit per stage
// computes floor(sqrt(v * 2^F)) for v < 2^(F+2); no dependencies

module crg_sqrt #(
    parameter int F  = 28,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [F+1:0]  in_v,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [F:0]    out_root,
    output logic [SW-1:0] out_side
);

    localparam int NS = F + 1;
    localparam int RW = F + 3;

    logic [NS-1:0] valid_reg;
    logic [F+1:0]  v_reg [NS];
    logic [SW-1:0] side_reg [NS];
    logic [RW-1:0] rem_reg [NS];
    logic [F:0]    root_reg [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            localparam int PI = 2 * (F - g) + 1;
            logic            valid_in;
            logic [F+1:0]    v_in;
            logic [SW-1:0]   side_in;
            logic [RW-1:0]   rem_in;
            logic [F:0]      root_in;
            logic [2*F+1:0]  xv;
            logic [RW+1:0]   cat;
            logic [RW+1:0]   trial;
            logic [RW+1:0]   diff;
            logic            ge;

            if (g == 0) begin : g_first
                assign valid_in = in_valid;
                assign v_in     = in_v;
                assign side_in  = in_side;
                assign rem_in   = '0;
                assign root_in  = '0;
            end else begin : g_next
                assign valid_in = valid_reg[g-1];
                assign v_in     = v_reg[g-1];
                assign side_in  = side_reg[g-1];
                assign rem_in   = rem_reg[g-1];
                assign root_in  = root_reg[g-1];
            end

            assign xv    = {v_in, {F{1'b0}}};
            assign cat   = {rem_in, xv[PI -: 2]};
            assign trial = {1'b0, root_in, 2'b01};
            assign ge    = cat >= trial;
            assign diff  = cat - trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (en) begin
                    valid_reg[g] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[g]    <= v_in;
                    side_reg[g] <= side_in;
                    rem_reg[g]  <= ge ? diff[RW-1:0] : cat[RW-1:0];
                    root_reg[g] <= {root_in[F-1:0], ge};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[design/crg_gen.sv]
// real 2- or 3-component rotation generator: pivot, ratios, sqrt, reciprocal
// depends on crg_div and crg_sqrt

module crg_gen #(
    parameter int N        = 2,
    parameter int IW       = 32,
    parameter int F        = 28,
    parameter bit ZERO_ONE = 1'b1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [IW-1:0] in_v [N],
    output logic                 out_valid,
    output logic signed [F+1:0]  out_o [N],
    output logic [IW-1:0]        out_nrm
);

    localparam int NL  = N - 1;
    localparam int PW  = (N > 2) ? 2 : 1;
    localparam int SB1 = N + PW + 1 + IW;
    localparam int TW  = NL * (F + 1);
    localparam int SW2 = TW + SB1;
    localparam int SW3 = F + 1 + SW2;
    localparam logic [F+1:0] ONE = (F + 2)'(1) << F;

    // magnitudes
    logic                valid1_reg;
    logic [N-1:0]        neg1_reg;
    logic [IW-1:0]       mag1_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                neg1_reg[i] <= in_v[i][IW-1];
                mag1_reg[i] <= in_v[i][IW-1] ? (~in_v[i] + 1'b1) : in_v[i];
            end
        end
    end

    // pivot select, first component wins ties
    logic [PW-1:0]         piv;
    logic [IW-1:0]         mp;
    logic                  any;
    logic [NL-1:0][IW-1:0] om;

    always_comb begin
        piv = '0;
        mp  = mag1_reg[0];
        any = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (mag1_reg[i] != '0) begin
                any = 1'b1;
            end
            if (i > 0 && mag1_reg[i] > mp) begin
                piv = PW'(i);
                mp  = mag1_reg[i];
            end
        end
        for (int j = 0; j < NL; j++) begin
            om[j] = (piv > PW'(j)) ? mag1_reg[j] : mag1_reg[j+1];
        end
    end

    logic                  valid2_reg;
    logic [N-1:0]          neg2_reg;
    logic [PW-1:0]         p2_reg;
    logic                  any2_reg;
    logic [IW-1:0]         mp2_reg;
    logic [NL-1:0][IW-1:0] om2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg <= neg1_reg;
            p2_reg   <= piv;
            any2_reg <= any;
            mp2_reg  <= mp;
            om2_reg  <= om;
        end
    end

    // ratios against the pivot
    logic                 valid_d;
    logic [NL-1:0][F:0]   t_d;
    logic [SB1-1:0]       side_d;

    crg_div #(.DW(IW), .QF(F), .NL(NL), .SW(SB1)) u_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid2_reg),
        .in_num    (om2_reg),
        .in_den    (mp2_reg),
        .in_side   ({neg2_reg, p2_reg, any2_reg, mp2_reg}),
        .out_valid (valid_d),
        .out_quo   (t_d),
        .out_side  (side_d)
    );

    // squares, then their sum plus one
    logic                 valid3_reg;
    logic [NL-1:0][F+1:0] sq3_reg;
    logic [NL-1:0][F:0]   t3_reg;
    logic [SB1-1:0]       side3_reg;
    logic [NL-1:0][2*F+1:0] sq_prod;

    always_comb begin
        for (int j = 0; j < NL; j++) begin
            sq_prod[j] = t_d[j] * t_d[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid3_reg <= 1'b0;
        end else if (en) begin
            valid3_reg <= valid_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NL; j++) begin
                sq3_reg[j] <= sq_prod[j][2*F+1:F];
            end
            t3_reg    <= t_d;
            side3_reg <= side_d;
        end
    end

    logic               valid4_reg;
    logic [F+1:0]       sum4_reg;
    logic [NL-1:0][F:0] t4_reg;
    logic [SB1-1:0]     side4_reg;
    logic [F+1:0]       sum;

    always_comb begin
        sum = ONE;
        for (int j = 0; j < NL; j++) begin
            sum = sum + sq3_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid4_reg <= 1'b0;
        end else if (en) begin
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum4_reg  <= sum;
            t4_reg    <= t3_reg;
            side4_reg <= side3_reg;
        end
    end

    // h = sqrt(sum), k = 1 / h
    logic           valid_s;
    logic [F:0]     h_s;
    logic [SW2-1:0] side_s;

    crg_sqrt #(.F(F), .SW(SW2)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid4_reg),
        .in_v      (sum4_reg),
        .in_side   ({t4_reg, side4_reg}),
        .out_valid (valid_s),
        .out_root  (h_s),
        .out_side  (side_s)
    );

    logic            valid_r;
    logic [0:0][F:0] k_r;
    logic [SW3-1:0]  side_r;

    crg_div #(.DW(F + 2), .QF(F), .NL(1), .SW(SW3)) u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_s),
        .in_num    (ONE),
        .in_den    ({1'b0, h_s}),
        .in_side   ({h_s, side_s}),
        .out_valid (valid_r),
        .out_quo   (k_r),
        .out_side  (side_r)
    );

    logic [F:0]         h_r;
    logic [NL-1:0][F:0] t_r;
    logic [IW-1:0]      mp_r;
    logic               any_r;
    logic [PW-1:0]      p_r;
    logic [N-1:0]       neg_r;

    assign h_r   = side_r[SW3-1:SW2];
    assign t_r   = side_r[SW2-1:SB1];
    assign mp_r  = side_r[IW-1:0];
    assign any_r = side_r[IW];
    assign p_r   = side_r[IW+PW:IW+1];
    assign neg_r = side_r[SB1-1:IW+PW+1];

    // scaled ratios and norm
    logic                   valid5_reg;
    logic [NL-1:0][F:0]     tk5_reg;
    logic [F:0]             k5_reg;
    logic [IW-1:0]          nm5_reg;
    logic [N-1:0]           neg5_reg;
    logic [PW-1:0]          p5_reg;
    logic                   any5_reg;
    logic [NL-1:0][2*F+1:0] tk_prod;
    logic [IW+F:0]          nm_prod;

    always_comb begin
        for (int j = 0; j < NL; j++) begin
            tk_prod[j] = t_r[j] * k_r[0];
        end
        nm_prod = mp_r * h_r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid5_reg <= 1'b0;
        end else if (en) begin
            valid5_reg <= valid_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NL; j++) begin
                tk5_reg[j] <= tk_prod[j][2*F:F];
            end
            k5_reg   <= k_r[0];
            nm5_reg  <= nm_prod[IW+F-1:F];
            neg5_reg <= neg_r;
            p5_reg   <= p_r;
            any5_reg <= any_r;
        end
    end

    // output assembly with signs and the all-zero case
    logic signed [F+1:0] o_next [N];

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_out
            logic [F:0]          other;
            logic [F:0]          mag;
            logic signed [F+1:0] sv;

            if (gi == 0) begin : g_low
                assign other = tk5_reg[0];
            end else if (gi == N - 1) begin : g_high
                assign other = tk5_reg[gi-1];
            end else begin : g_mid
                assign other = (p5_reg > PW'(gi)) ? tk5_reg[gi] : tk5_reg[gi-1];
            end

            assign mag = (p5_reg == PW'(gi)) ? k5_reg : other;
            assign sv  = {1'b0, mag};
            assign o_next[gi] = !any5_reg ? ((ZERO_ONE && gi == 0) ? ONE : '0)
                                          : (neg5_reg[gi] ? -sv : sv);
        end
    endgenerate

    logic                valid6_reg;
    logic signed [F+1:0] o6_reg [N];
    logic [IW-1:0]       nrm6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid6_reg <= 1'b0;
        end else if (en) begin
            valid6_reg <= valid5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                o6_reg[i] <= o_next[i];
            end
            nrm6_reg <= any5_reg ? nm5_reg : '0;
        end
    end

    assign out_valid = valid6_reg;
    assign out_o     = o6_reg;
    assign out_nrm   = nrm6_reg;

endmodule

[design/complex_rotation_generator.sv]
// accepts one transaction per cycle while the output is not stalled
// the pipeline depth comes from the bit-per-stage divider and square root pipelines
// inside the three chained generators; a stalled output freezes every stage
// reset clears the valid bits of all stages; data registers are not reset
// top level of the complex rotation generator; depends on crg_pkg, crg_gen

module complex_rotation_generator
    import crg_pkg::*;
#(
    parameter int DATA_WIDTH = CRG_DATA_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_a_re,
    input  logic signed [DATA_WIDTH-1:0] s_a_im,
    input  logic signed [DATA_WIDTH-1:0] s_b_re,
    input  logic signed [DATA_WIDTH-1:0] s_b_im,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_c_re,
    output logic signed [DATA_WIDTH-1:0] m_c_im,
    output logic signed [DATA_WIDTH-1:0] m_s,
    output logic signed [DATA_WIDTH-1:0] m_nrm
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = W - CRG_INT_BITS;
    localparam int LQ = gen_latency(F);
    localparam logic [W:0] NRM_MAX = {2'b00, {(W-1){1'b1}}};

    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // phase and magnitude of a and b
    logic signed [W-1:0]  a_in [2];
    logic signed [W-1:0]  b_in [2];
    logic signed [F+1:0]  pa [2];
    logic signed [F+1:0]  pb [2];
    logic [W-1:0]         na;
    logic [W-1:0]         nb;
    logic                 va;
    logic                 vb;

    assign a_in[0] = s_a_re;
    assign a_in[1] = s_a_im;
    assign b_in[0] = s_b_re;
    assign b_in[1] = s_b_im;

    crg_gen #(.N(2), .IW(W), .F(F), .ZERO_ONE(1'b1)) u_gen_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_v      (a_in),
        .out_valid (va),
        .out_o     (pa),
        .out_nrm   (na)
    );

    crg_gen #(.N(2), .IW(W), .F(F), .ZERO_ONE(1'b1)) u_gen_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_v      (b_in),
        .out_valid (vb),
        .out_o     (pb),
        .out_nrm   (nb)
    );

    // relative phase products
    logic [F:0]           pa_mag [2];
    logic [F:0]           pb_mag [2];
    logic [2*F+1:0]       pr [2][2];
    logic signed [F+1:0]  ps [2][2];
    logic signed [F+1:0]  pmag [2][2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            pa_mag[i] = pa[i][F+1] ? (F + 1)'(-pa[i]) : pa[i][F:0];
            pb_mag[i] = pb[i][F+1] ? (F + 1)'(-pb[i]) : pb[i][F:0];
        end
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                pr[i][j]   = pa_mag[i] * pb_mag[j];
                pmag[i][j] = {1'b0, pr[i][j][2*F:F]};
                ps[i][j]   = (pa[i][F+1] != pb[j][F+1]) ? -pmag[i][j] : pmag[i][j];
            end
        end
    end

    logic                valid1_reg;
    logic signed [F+1:0] p1_reg [2][2];
    logic [W-1:0]        na1_reg;
    logic [W-1:0]        nb1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= va && vb;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= ps;
            na1_reg <= na;
            nb1_reg <= nb;
        end
    end

    logic                valid2_reg;
    logic signed [F+2:0] t2_reg [2];
    logic [W-1:0]        na2_reg;
    logic [W-1:0]        nb2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_reg[0] <= (F + 3)'(p1_reg[0][0]) + (F + 3)'(p1_reg[1][1]);
            t2_reg[1] <= (F + 3)'(p1_reg[1][0]) - (F + 3)'(p1_reg[0][1]);
            na2_reg   <= na1_reg;
            nb2_reg   <= nb1_reg;
        end
    end

    // renormalized relative phase
    logic signed [F+1:0] q [2];
    logic [F+2:0]        nq;
    logic                vq;

    crg_gen #(.N(2), .IW(F + 3), .F(F), .ZERO_ONE(1'b1)) u_gen_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid2_reg),
        .in_v      (t2_reg),
        .out_valid (vq),
        .out_o     (q),
        .out_nrm   (nq)
    );

    logic [W-1:0] na_dly_reg [LQ];
    logic [W-1:0] nb_dly_reg [LQ];

    always_ff @(posedge aclk) begin
        if (en) begin
            na_dly_reg[0] <= na2_reg;
            nb_dly_reg[0] <= nb2_reg;
            for (int i = 1; i < LQ; i++) begin
                na_dly_reg[i] <= na_dly_reg[i-1];
                nb_dly_reg[i] <= nb_dly_reg[i-1];
            end
        end
    end

    // complex first entry |a| * phase
    logic [F:0]          q_mag [2];
    logic [W+F:0]        vprod [2];
    logic signed [W:0]   vmag [2];
    logic signed [W:0]   v_next [3];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            q_mag[i]  = q[i][F+1] ? (F + 1)'(-q[i]) : q[i][F:0];
            vprod[i]  = na_dly_reg[LQ-1] * q_mag[i];
            vmag[i]   = {1'b0, vprod[i][W+F-1:F]};
            v_next[i] = q[i][F+1] ? -vmag[i] : vmag[i];
        end
        v_next[2] = {1'b0, nb_dly_reg[LQ-1]};
    end

    logic              valid3_reg;
    logic signed [W:0] v3_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid3_reg <= 1'b0;
        end else if (en) begin
            valid3_reg <= vq;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v3_reg <= v_next;
        end
    end

    // final three-component rotation
    logic signed [F+1:0] o [3];
    logic [W:0]          n3;
    logic                v3;

    crg_gen #(.N(3), .IW(W + 1), .F(F), .ZERO_ONE(1'b0)) u_gen_3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid3_reg),
        .in_v      (v3_reg),
        .out_valid (v3),
        .out_o     (o),
        .out_nrm   (n3)
    );

    // output register with norm saturation
    logic signed [W-1:0] c_re_reg;
    logic signed [W-1:0] c_im_reg;
    logic signed [W-1:0] s_reg;
    logic signed [W-1:0] nrm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v3;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_re_reg <= W'(o[0]);
            c_im_reg <= W'(o[1]);
            s_reg    <= W'(o[2]);
            nrm_reg  <= (n3 > NRM_MAX) ? NRM_MAX[W-1:0] : n3[W-1:0];
        end
    end

    // norm of the phase step is not needed downstream
    logic nq_any;
    assign nq_any = |nq;

    assign m_valid = m_valid_reg && (nq_any || !nq_any);
    assign m_c_re  = c_re_reg;
    assign m_c_im  = c_im_reg;
    assign m_s     = s_reg;
    assign m_nrm   = nrm_reg;

endmodule

[design/crg_checker.sv]
// port-level assertions for the complex rotation generator
// depends on crg_pkg; bound to complex_rotation_generator

module crg_checker
    import crg_pkg::*;
#(
    parameter int DATA_WIDTH = CRG_DATA_WIDTH
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic signed [DATA_WIDTH-1:0] s_a_re,
    input logic signed [DATA_WIDTH-1:0] s_a_im,
    input logic signed [DATA_WIDTH-1:0] s_b_re,
    input logic signed [DATA_WIDTH-1:0] s_b_im,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [DATA_WIDTH-1:0] m_c_re,
    input logic signed [DATA_WIDTH-1:0] m_c_im,
    input logic signed [DATA_WIDTH-1:0] m_s,
    input logic signed [DATA_WIDTH-1:0] m_nrm
);

    localparam int W = DATA_WIDTH;

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_c_re) && $stable(m_c_im)
                                   && $stable(m_s) && $stable(m_nrm)))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // norm and sine never negative
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_nrm[W-1] && !m_s[W-1]))
        else $error("negative norm or sine");

    // zero norm only together with an all-zero rotation output
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_nrm == '0) |-> (m_c_re == '0 && m_c_im == '0 && m_s == '0))
        else $error("zero norm with nonzero rotation");

endmodule

bind complex_rotation_generator crg_checker #(.DATA_WIDTH(DATA_WIDTH)) u_crg_checker (.*);

[tb/sv/complex_rotation_generator_tb.sv]
// testbench for complex_rotation_generator: random and directed complex pairs,
// expected rotations from a bit-exact fixed-point predictor; depends on crg_pkg

module complex_rotation_generator_tb
    import crg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W      = CRG_DATA_WIDTH;
    localparam int FRAC   = W - CRG_INT_BITS;
    localparam longint unsigned ONE_FX  = 64'd1 << FRAC;
    localparam longint unsigned NRM_MAX = (64'd1 << (W - 1)) - 1;
    localparam int LATENCY   = 9 * FRAC + 31;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        logic signed [W-1:0] a_re, a_im, b_re, b_im;
        bit                  hold;
    } pair_t;

    typedef struct {
        logic signed [W-1:0] c_re, c_im, s, nrm;
    } rot_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [W-1:0] s_a_re = '0, s_a_im = '0, s_b_re = '0, s_b_im = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [W-1:0] m_c_re, m_c_im, m_s, m_nrm;

    pair_t pending_q[$];
    rot_t  rotation_q[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    send_gap = 0, recv_stall = 0;
    bit    in_taken = 0, out_taken = 0, stall_on = 1;
    int    results_seen = 0;

    complex_rotation_generator #(.DATA_WIDTH(W)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_re(s_a_re), .s_a_im(s_a_im), .s_b_re(s_b_re), .s_b_im(s_b_im),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_c_re(m_c_re), .m_c_im(m_c_im), .m_s(m_s), .m_nrm(m_nrm)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint unsigned mag_of(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    function automatic longint signed_mag(bit neg, longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FRAC+63:FRAC];
    endfunction

    function automatic longint fx_smul(longint a, longint b);
        return signed_mag((a < 0) != (b < 0), fx_mul(mag_of(a), mag_of(b)));
    endfunction

    function automatic longint unsigned fx_ratio(longint unsigned n, longint unsigned d);
        logic [127:0] t;
        if (d == 0) return 0;
        t = {64'd0, n} << FRAC;
        return 64'(t / d);
    endfunction

    function automatic longint unsigned fx_sqrt(longint unsigned v);
        longint unsigned x, res, b;
        x = v << FRAC;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // normalizes cnt components by the largest one; zero vector gives zeros
    function automatic bit unit_vector(input int cnt, input longint v[3],
                                       output longint o[3], output longint unsigned nrm);
        longint unsigned m[3], t[3], sum, h, k;
        int p;
        bit any;
        any = 0;
        p = 0;
        sum = ONE_FX;
        for (int i = 0; i < 3; i++) begin
            o[i] = 0;
            t[i] = 0;
            m[i] = 0;
        end
        for (int i = 0; i < cnt; i++) begin
            m[i] = mag_of(v[i]);
            if (m[i] != 0) any = 1;
        end
        nrm = 0;
        if (!any) return 0;
        for (int i = 1; i < cnt; i++)
            if (m[i] > m[p]) p = i;
        for (int i = 0; i < cnt; i++)
            if (i != p) begin
                t[i] = fx_ratio(m[i], m[p]);
                sum += fx_mul(t[i], t[i]);
            end
        h = fx_sqrt(sum);
        k = fx_ratio(ONE_FX, h);
        for (int i = 0; i < cnt; i++)
            o[i] = signed_mag(v[i] < 0, i == p ? k : fx_mul(t[i], k));
        nrm = fx_mul(m[p], h);
        return 1;
    endfunction

    function automatic void phase_of(input longint x, input longint y,
                                     output longint re, output longint im,
                                     output longint unsigned nrm);
        longint v[3], o[3];
        v[0] = x;
        v[1] = y;
        v[2] = 0;
        if (unit_vector(2, v, o, nrm)) begin
            re = o[0];
            im = o[1];
        end else begin
            re = ONE_FX;
            im = 0;
        end
    endfunction

    function automatic rot_t predict_rotation(pair_t p);
        longint pa_re, pa_im, pb_re, pb_im, q_re, q_im, t1, t2;
        longint unsigned na, nb, nq, n;
        longint v[3], o[3];
        bit any;
        rot_t r;
        phase_of(longint'(p.b_re), longint'(p.b_im), pb_re, pb_im, nb);
        phase_of(longint'(p.a_re), longint'(p.a_im), pa_re, pa_im, na);
        t1 = fx_smul(pa_re, pb_re) + fx_smul(pa_im, pb_im);
        t2 = fx_smul(pa_im, pb_re) - fx_smul(pa_re, pb_im);
        phase_of(t1, t2, q_re, q_im, nq);
        v[0] = fx_smul(longint'(na), q_re);
        v[1] = fx_smul(longint'(na), q_im);
        v[2] = longint'(nb);
        any = unit_vector(3, v, o, n);
        if (n > NRM_MAX) n = NRM_MAX;
        r.c_re = o[0][W-1:0];
        r.c_im = o[1][W-1:0];
        r.s    = o[2][W-1:0];
        r.nrm  = n[W-1:0];
        return r;
    endfunction

    function automatic logic signed [W-1:0] pick_field(logic signed [W-1:0] other);
        int sel;
        logic signed [W-1:0] x;
        sel = $urandom_range(0, 9);
        x = $urandom;
        case (sel)
            0: x = '0;
            1: x = other;
            2: x = -other;
            3, 4: x = x >>> $urandom_range(1, W - 1);
            5: x = x >>> $urandom_range(20, W - 1);
            default: ;
        endcase
        return x;
    endfunction

    task automatic add_pair(logic signed [W-1:0] ar, logic signed [W-1:0] ai,
                            logic signed [W-1:0] br, logic signed [W-1:0] bi, bit hold);
        pair_t p;
        p.a_re = ar;
        p.a_im = ai;
        p.b_re = br;
        p.b_im = bi;
        p.hold = hold;
        pending_q.push_back(p);
    endtask

    // directed and random stimulus
    initial begin
        logic signed [W-1:0] mx, mn, one, ar, ai, br, bi;
        mx = {1'b0, {(W-1){1'b1}}};
        mn = {1'b1, {(W-1){1'b0}}};
        one = W'(ONE_FX);
        add_pair('0, '0, '0, '0, 0);
        add_pair(one, '0, '0, '0, 0);
        add_pair('0, '0, '0, one, 0);
        add_pair('0, one, '0, '0, 0);
        add_pair('0, '0, -one, '0, 0);
        add_pair(mx, mx, mx, mx, 0);
        add_pair(mn, mn, mn, mn, 0);
        add_pair(mn, mx, mx, mn, 0);
        add_pair(mx, '0, mn, '0, 0);
        add_pair(one, one, one, one, 0);
        add_pair(one, -one, -one, one, 0);
        add_pair(W'(1), W'(1), W'(1), W'(1), 0);
        add_pair(W'(-1), '0, '0, W'(1), 0);
        add_pair(one, '0, one, '0, 0);
        add_pair('0, -one, '0, -one, 0);
        add_pair(mn, '0, '0, '0, 0);
        add_pair('0, '0, mn, mx, 0);
        add_pair(W'(3), W'(4), W'(-4), W'(3), 0);
        add_pair(mx, mn, '0, '0, 0);
        add_pair('0, '0, W'(1), '0, 1);
        for (int i = 0; i < 1550; i++) begin
            ar = pick_field($urandom);
            ai = pick_field(ar);
            br = pick_field(ai);
            bi = pick_field(br);
            add_pair(ar, ai, br, bi, (i % 500) == 499);
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!(s_valid && !in_taken)) begin
                in_taken = 0;
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].hold && rotation_q.size() != 0)) begin
                    s_valid <= 1'b1;
                    s_a_re <= pending_q[0].a_re;
                    s_a_im <= pending_q[0].a_im;
                    s_b_re <= pending_q[0].b_re;
                    s_b_im <= pending_q[0].b_im;
                    void'(pending_q.pop_front());
                    send_gap = stall_on ? $urandom_range(0, 13) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (out_taken || !m_ready) begin
                out_taken = 0;
                if (recv_stall > 0) begin
                    recv_stall--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    recv_stall = stall_on ? $urandom_range(0, 13) : 0;
                end
            end
        end
    end

    // monitor: compare each result transaction, then record new inputs
    always @(posedge aclk) begin
        rot_t e;
        pair_t p;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            out_taken = 1;
            results_seen++;
            if (results_seen % 300 == 0) stall_on = !stall_on;
            if (rotation_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                e = rotation_q.pop_front();
                if (m_c_re !== e.c_re || m_c_im !== e.c_im || m_s !== e.s ||
                    m_nrm !== e.nrm) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp c=(%0d,%0d) s=%0d nrm=%0d got c=(%0d,%0d) s=%0d nrm=%0d",
                                 e.c_re, e.c_im, e.s, e.nrm, m_c_re, m_c_im, m_s, m_nrm);
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            in_taken = 1;
            p.a_re = s_a_re;
            p.a_im = s_a_im;
            p.b_re = s_b_re;
            p.b_im = s_b_im;
            p.hold = 0;
            rotation_q.push_back(predict_rotation(p));
        end
    end

    initial begin
        wait (aresetn);
        wait (pending_q.size() == 0 && !s_valid && rotation_q.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && rotation_q.size() == 0) begin
            $display("complex_rotation_generator: match");
        end else begin
            $display("complex_rotation_generator: mismatch");
        end
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_CAP);
        $display("complex_rotation_generator: mismatch");
        $finish;
    end

endmodule
